@@ sv/ldi_pkg.sv @@
// Package: shared types, widths and codes for the direct interaction core.
`timescale 1ns / 1ps
package ldi_pkg;

  // Command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SOURCE_COUNT = 2'd0;
  localparam logic [1:0] CFG_IMAGE_X      = 2'd1;
  localparam logic [1:0] CFG_IMAGE_Y      = 2'd2;
  localparam logic [1:0] CFG_IMAGE_Z      = 2'd3;

  // Datapath widths
  localparam int unsigned DIFF_W  = 34;   // separation, Q8.24 plus growth
  localparam int unsigned SQ_W    = 68;   // sum of squared separations
  localparam int unsigned RAD_W   = 100;  // radicand S * 2^32
  localparam int unsigned ROOT_W  = 50;   // r in units of 2^-40
  localparam int unsigned REM_W   = 53;   // square root remainder
  localparam int unsigned NUM_W   = 120;  // dividend
  localparam int unsigned DEN_W   = 100;  // divisor (W or W^2)
  localparam int unsigned UNIT_W  = 31;   // unit vector component, Q1.30
  localparam int unsigned PROD_W  = 62;   // charge times unit component
  localparam int unsigned POT_W   = 64;   // potential term magnitude
  localparam int unsigned FRC_W   = 88;   // force term magnitude
  localparam int unsigned ACC_W   = 100;  // wide accumulator

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_ZCHECK,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_POT_GO,
    ST_POT_WAIT,
    ST_UNIT_GO,
    ST_UNIT_WAIT,
    ST_MUL,
    ST_FORCE_GO,
    ST_FORCE_WAIT,
    ST_NEXT,
    ST_FINISH
  } state_e;

endpackage

@@ sv/ldi_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ldi_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/ldi_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ldi_divider #(
  parameter int unsigned NW = 120,
  parameter int unsigned DW = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    n_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, n_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = n_q;

  // Count iterations
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold dividend, quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && (cnt_q != '0)) begin
      n_q   <= {n_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

@@ sv/ldi_sqrt.sv @@
// Digit-by-digit integer square root with remainder, one root bit per cycle.
`timescale 1ns / 1ps
module ldi_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ldi_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [ldi_pkg::ROOT_W-1:0]  root_o,
  output logic [ldi_pkg::REM_W-1:0]   rem_o
);
  import ldi_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RAD_W-1:0] rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;
  logic             ge;

  // Bring down two radicand bits and try root*4+1
  assign cur   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = cur >= trial;

  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance one root digit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], ge};
      rem_q  <= ge ? (cur - trial) : cur;
    end
  end

endmodule

@@ sv/laplace_direct_interaction_core.sv @@
// Top level: source memory, pair sequencer and accumulators.
`timescale 1ns / 1ps
// Direct Coulomb kernel. A store item (cmd 0) writes one source into the source
// RAM in the cycle it is accepted and causes no result. An evaluate item walks
// sources 0 .. min(source_count, MAX_SOURCES)-1 one at a time and returns one
// result with the saturated Q32.32 potential and force. Each source at nonzero
// distance takes the read, the separations, three squares, the zero check, a
// square root (start, 50 root digits, done), seven bit-serial divisions (start,
// 120 quotient bits, done) for the potential, three unit components and three
// force components on one shared divider, three multiplies and the step to the
// next source. A coincident source goes from the zero check straight to the
// next source. After the last source the finish state loads the output
// register; it waits there while that register still holds a result nobody
// has taken. The result sits in an output register, so the next item is
// accepted while it waits.
module laplace_direct_interaction_core #(
  parameter int unsigned MAX_SOURCES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  slot_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] charge_i,
  input  logic signed [63:0] prior_potential_i,
  input  logic signed [63:0] prior_force_x_i,
  input  logic signed [63:0] prior_force_y_i,
  input  logic signed [63:0] prior_force_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [63:0] potential_o,
  output logic signed [63:0] force_x_o,
  output logic signed [63:0] force_y_o,
  output logic signed [63:0] force_z_o
);
  import ldi_pkg::*;

  localparam int unsigned AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned CW = $clog2(MAX_SOURCES + 1);

  state_e state_q, state_d;

  // Configuration
  logic [8:0]  src_cnt_q;
  logic [31:0] off_q [3];

  // Item context
  logic [CW-1:0]  n_q, idx_q;
  logic [1:0]     ax_q;
  logic [31:0]    tgt_q [3];
  logic [ACC_W-1:0] acc_q [4];
  logic [DIFF_W-1:0] ad_q [3];
  logic [2:0]     dneg_q;
  logic [31:0]    aq_q;
  logic           qneg_q;
  logic [SQ_W-1:0] s_q;
  logic [ROOT_W-1:0] w_q;
  logic [DEN_W-1:0] w2_q;
  logic [UNIT_W-1:0] u_q;
  logic [PROD_W-1:0] prod_q;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] res_q [4];

  // Memory
  logic           ram_we;
  logic [127:0]   ram_rdata;
  logic [AW-1:0]  ram_raddr;
  logic [31:0]    src_pos [3];
  logic [31:0]    src_q;

  // Shared units
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [REM_W-1:0]  sqrt_rem;
  logic [RAD_W-1:0]  rad;

  logic in_acc, out_acc, fin_go;
  logic [CW-1:0] n_new;
  logic [DIFF_W-1:0] d_new [3];
  logic [SQ_W-1:0] sq_prod;
  logic [DIFF_W-1:0] ad_sel;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign fin_go  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign ram_we  = in_acc && (cmd_i == CMD_STORE) && (32'(slot_i) < MAX_SOURCES);
  assign n_new   = (32'(src_cnt_q) > MAX_SOURCES) ? CW'(MAX_SOURCES) : CW'(src_cnt_q);

  assign src_pos[0] = ram_rdata[127:96];
  assign src_pos[1] = ram_rdata[95:64];
  assign src_pos[2] = ram_rdata[63:32];
  assign src_q      = ram_rdata[31:0];

  // Form separations for the source just read
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_new[a] = {{2{tgt_q[a][31]}}, tgt_q[a]} - {{2{src_pos[a][31]}}, src_pos[a]}
               - {{2{off_q[a][31]}}, off_q[a]};
    end
  end

  assign ad_sel  = ad_q[ax_q];
  assign sq_prod = SQ_W'(ad_sel) * SQ_W'(ad_sel);
  assign rad     = {s_q, 32'd0};

  ldi_ram #(.WIDTH(128), .DEPTH(MAX_SOURCES)) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(slot_i)),
    .wdata_i({pos_x_i, pos_y_i, pos_z_i, charge_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ldi_divider #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  ldi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .rad_i  (rad),
    .done_o (sqrt_done),
    .root_o (sqrt_root),
    .rem_o  (sqrt_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_i == CMD_EVAL)) begin
          state_d = (n_new == '0) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ:      state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_SQUARE;
      ST_SQUARE:    state_d = (ax_q == 2'd2) ? ST_ZCHECK : ST_SQUARE;
      ST_ZCHECK:    state_d = (s_q == '0) ? ST_NEXT : ST_SQRT_GO;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: state_d = sqrt_done ? ST_POT_GO : ST_SQRT_WAIT;
      ST_POT_GO:    state_d = ST_POT_WAIT;
      ST_POT_WAIT:  state_d = div_done ? ST_UNIT_GO : ST_POT_WAIT;
      ST_UNIT_GO:   state_d = ST_UNIT_WAIT;
      ST_UNIT_WAIT: state_d = div_done ? ST_MUL : ST_UNIT_WAIT;
      ST_MUL:       state_d = ST_FORCE_GO;
      ST_FORCE_GO:  state_d = ST_FORCE_WAIT;
      ST_FORCE_WAIT: begin
        if (div_done) begin
          state_d = (ax_q == 2'd2) ? ST_NEXT : ST_UNIT_GO;
        end
      end
      ST_NEXT:      state_d = (idx_q + 1'b1 == n_q) ? ST_FINISH : ST_READ;
      ST_FINISH:    state_d = fin_go ? ST_IDLE : ST_FINISH;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_num    = NUM_W'({aq_q, 48'd0});
    div_den    = DEN_W'(w_q);
    ram_raddr  = idx_q[AW-1:0];
    case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_SQRT_GO:  sqrt_start = 1'b1;
      ST_POT_GO:   div_start  = 1'b1;
      ST_UNIT_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'({ad_sel, 46'd0});
      end
      ST_FORCE_GO: begin
        div_start = 1'b1;
        div_num   = {prod_q, 58'd0};
        div_den   = w2_q;
      end
      default: ;
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (fin_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      src_cnt_q   <= '0;
      off_q[0]    <= '0;
      off_q[1]    <= '0;
      off_q[2]    <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      ax_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // Take configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_COUNT: src_cnt_q <= cfg_data_i[8:0];
          CFG_IMAGE_X:      off_q[0]  <= cfg_data_i;
          CFG_IMAGE_Y:      off_q[1]  <= cfg_data_i;
          CFG_IMAGE_Z:      off_q[2]  <= cfg_data_i;
          default: ;
        endcase
      end
      // Advance source index and axis
      case (state_q)
        ST_IDLE: begin
          n_q   <= n_new;
          idx_q <= '0;
        end
        ST_DIFF:     ax_q <= '0;
        ST_SQUARE:   ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
        ST_FORCE_WAIT: begin
          if (div_done) begin
            ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
          end
        end
        ST_NEXT:     idx_q <= idx_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_i == CMD_EVAL)) begin
          tgt_q[0] <= pos_x_i;
          tgt_q[1] <= pos_y_i;
          tgt_q[2] <= pos_z_i;
          acc_q[0] <= ACC_W'(prior_potential_i);
          acc_q[1] <= ACC_W'(prior_force_x_i);
          acc_q[2] <= ACC_W'(prior_force_y_i);
          acc_q[3] <= ACC_W'(prior_force_z_i);
        end
      end
      ST_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          dneg_q[a] <= d_new[a][DIFF_W-1];
          ad_q[a]   <= d_new[a][DIFF_W-1] ? (DIFF_W'(0) - d_new[a]) : d_new[a];
        end
        qneg_q <= src_q[31];
        aq_q   <= src_q[31] ? (32'd0 - src_q) : src_q;
        s_q    <= '0;
      end
      ST_SQUARE: s_q <= s_q + sq_prod;
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          w_q  <= sqrt_root;
          w2_q <= rad - DEN_W'(sqrt_rem);
        end
      end
      ST_POT_WAIT: begin
        if (div_done) begin
          acc_q[0] <= qneg_q ? acc_q[0] - ACC_W'(div_quo[POT_W-1:0])
                             : acc_q[0] + ACC_W'(div_quo[POT_W-1:0]);
        end
      end
      ST_UNIT_WAIT: begin
        if (div_done) begin
          u_q <= div_quo[UNIT_W-1:0];
        end
      end
      ST_MUL: prod_q <= PROD_W'(aq_q) * PROD_W'(u_q);
      ST_FORCE_WAIT: begin
        if (div_done) begin
          // Force points toward a positive source and away from a negative one: negate when signs agree
          acc_q[ax_q + 1] <= (qneg_q == dneg_q[ax_q])
                             ? acc_q[ax_q + 1] - ACC_W'(div_quo[FRC_W-1:0])
                             : acc_q[ax_q + 1] + ACC_W'(div_quo[FRC_W-1:0]);
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          for (int k = 0; k < 4; k++) begin
            if (acc_q[k][ACC_W-1:63] == '0 || acc_q[k][ACC_W-1:63] == '1) begin
              res_q[k] <= acc_q[k][63:0];
            end else begin
              res_q[k] <= acc_q[k][ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign potential_o = res_q[0];
  assign force_x_o   = res_q[1];
  assign force_y_o   = res_q[2];
  assign force_z_o   = res_q[3];

  // Divider completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_POT_WAIT || state_q == ST_UNIT_WAIT ||
                  state_q == ST_FORCE_WAIT))
    else $error("divider finished outside a wait state");

  // Square root completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_SQRT_WAIT))
    else $error("square root finished outside its wait state");

  // Every memory read addresses a source that takes part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (idx_q < n_q))
    else $error("source index beyond count");

  // A finished evaluation always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q)
    else $error("result lost at finish");

endmodule

@@ test/ldi_result_checker.sv @@
// Checker: watches both channels, predicts the result sums and compares them.
`timescale 1ns / 1ps
module ldi_result_checker #(
  parameter int unsigned MAX_SOURCES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [7:0]  slot_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] charge_i,
  input  logic [63:0] prior_potential_i,
  input  logic [63:0] prior_force_x_i,
  input  logic [63:0] prior_force_y_i,
  input  logic [63:0] prior_force_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] potential_i,
  input  logic [63:0] force_x_i,
  input  logic [63:0] force_y_i,
  input  logic [63:0] force_z_i,
  output int          mismatches_o,
  output int          pending_o
);
  import ldi_pkg::*;

  typedef struct packed {
    logic [63:0] potential;
    logic [63:0] force_x;
    logic [63:0] force_y;
    logic [63:0] force_z;
  } sums_t;

  // Shadow copy of the source memory and the registers
  logic [31:0] src_x [MAX_SOURCES];
  logic [31:0] src_y [MAX_SOURCES];
  logic [31:0] src_z [MAX_SOURCES];
  logic [31:0] src_q [MAX_SOURCES];
  logic [8:0]  n_sources;
  logic [31:0] image_x, image_y, image_z;

  sums_t expected_sums[$];
  int    fail_count = 0;

  assign pending_o    = expected_sums.size();
  assign mismatches_o = fail_count;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Floor square root of a radicand below 2^126
  function automatic logic [127:0] isqrt(input logic [127:0] x);
    logic [127:0] res;
    logic [127:0] c;
    res = '0;
    for (int b = 62; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= x) res = c;
    end
    return res;
  endfunction

  function automatic logic signed [127:0] apply_sign(input logic [127:0] mag, input bit neg);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [63:0] saturate(input logic signed [127:0] acc);
    if (acc[127:63] == '0 || acc[127:63] == '1) return acc[63:0];
    return acc[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  // Sum the Coulomb contributions of the active sources onto the prior sums
  function automatic sums_t compute_interaction();
    logic signed [127:0] acc [4];
    longint tgt [3];
    longint off [3];
    longint d [3];
    logic [127:0] ad [3];
    logic [127:0] aq, s, w, w2, u, f;
    longint q;
    int n;
    sums_t r;
    tgt[0] = longint'($signed(pos_x_i));
    tgt[1] = longint'($signed(pos_y_i));
    tgt[2] = longint'($signed(pos_z_i));
    off[0] = longint'($signed(image_x));
    off[1] = longint'($signed(image_y));
    off[2] = longint'($signed(image_z));
    acc[0] = 128'($signed(prior_potential_i));
    acc[1] = 128'($signed(prior_force_x_i));
    acc[2] = 128'($signed(prior_force_y_i));
    acc[3] = 128'($signed(prior_force_z_i));
    n = (n_sources > MAX_SOURCES) ? MAX_SOURCES : int'(n_sources);
    for (int i = 0; i < n; i++) begin
      q = longint'($signed(src_q[i]));
      d[0] = tgt[0] - longint'($signed(src_x[i])) - off[0];
      d[1] = tgt[1] - longint'($signed(src_y[i])) - off[1];
      d[2] = tgt[2] - longint'($signed(src_z[i])) - off[2];
      s = '0;
      for (int a = 0; a < 3; a++) begin
        ad[a] = 128'(d[a] < 0 ? -d[a] : d[a]);
        s += ad[a] * ad[a];
      end
      // coincident pair: no contribution
      if (s != '0) begin
        w = isqrt(s << 32);
        aq = 128'(q < 0 ? -q : q);
        acc[0] += apply_sign((aq << 48) / w, q < 0);
        w2 = w * w;
        for (int a = 0; a < 3; a++) begin
          u = (ad[a] << 46) / w;
          f = ((aq * u) << 58) / w2;
          acc[a + 1] += apply_sign(f, (q < 0) == (d[a] < 0));
        end
      end
    end
    r.potential = saturate(acc[0]);
    r.force_x   = saturate(acc[1]);
    r.force_y   = saturate(acc[2]);
    r.force_z   = saturate(acc[3]);
    return r;
  endfunction

  // Track registers, stores and evaluations; check results in order
  always @(posedge clk_i or negedge rst_ni) begin
    sums_t want;
    if (!rst_ni) begin
      n_sources <= '0;
      image_x   <= '0;
      image_y   <= '0;
      image_z   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_COUNT: n_sources <= cfg_data_i[8:0];
          CFG_IMAGE_X:      image_x   <= cfg_data_i;
          CFG_IMAGE_Y:      image_y   <= cfg_data_i;
          CFG_IMAGE_Z:      image_z   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_STORE) begin
          src_x[slot_i] <= pos_x_i;
          src_y[slot_i] <= pos_y_i;
          src_z[slot_i] <= pos_z_i;
          src_q[slot_i] <= charge_i;
        end else begin
          expected_sums.push_back(compute_interaction());
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("result with no evaluation pending");
        end else begin
          want = expected_sums.pop_front();
          if (potential_i !== want.potential)
            report_mismatch($sformatf("potential %h, want %h", potential_i, want.potential));
          if (force_x_i !== want.force_x)
            report_mismatch($sformatf("force_x %h, want %h", force_x_i, want.force_x));
          if (force_y_i !== want.force_y)
            report_mismatch($sformatf("force_y %h, want %h", force_y_i, want.force_y));
          if (force_z_i !== want.force_z)
            report_mismatch($sformatf("force_z %h, want %h", force_z_i, want.force_z));
        end
      end
    end
  end

endmodule

@@ test/tb_laplace_direct_interaction_core.sv @@
// Testbench top: drives stores, evaluations and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_laplace_direct_interaction_core;
  import ldi_pkg::*;

  localparam int unsigned NSRC       = 256;
  localparam int unsigned QUIET_LIMIT = 1_500_000;
  localparam int          HOLD_CYCLES = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [7:0]  slot_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i, charge_i;
  logic signed [63:0] prior_potential_i, prior_force_x_i, prior_force_y_i, prior_force_z_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [63:0] potential_o, force_x_o, force_y_o, force_z_o;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_req;
  bit hold_taken;
  logic [31:0] cluster;

  laplace_direct_interaction_core #(.MAX_SOURCES(NSRC)) DUT (.*);

  ldi_result_checker #(.MAX_SOURCES(NSRC)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .charge_i,
    .prior_potential_i, .prior_force_x_i, .prior_force_y_i, .prior_force_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .potential_i(potential_o), .force_x_i(force_x_o),
    .force_y_i(force_y_o), .force_z_i(force_z_o),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or one long hold-off once it is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Hand one item to the block and wait until it is taken
  task automatic send_item(input logic c, input logic [7:0] sl, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z, input logic [31:0] q,
                           input logic [63:0] p0, input logic [63:0] p1,
                           input logic [63:0] p2, input logic [63:0] p3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= c;
    slot_i            <= sl;
    pos_x_i           <= x;
    pos_y_i           <= y;
    pos_z_i           <= z;
    charge_i          <= q;
    prior_potential_i <= p0;
    prior_force_x_i   <= p1;
    prior_force_y_i   <= p2;
    prior_force_z_i   <= p3;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic store_source(input logic [7:0] sl, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input logic [31:0] q);
    send_item(CMD_STORE, sl, x, y, z, q, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic evaluate(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                          input logic [63:0] p0, input logic [63:0] p1,
                          input logic [63:0] p2, input logic [63:0] p3);
    send_item(CMD_EVAL, 8'($urandom), x, y, z, $urandom, p0, p1, p2, p3);
  endtask

  // Drain all results and let the block settle before registers are written
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [8:0] count, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] oz);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_SOURCE_COUNT; cfg_data_i <= 32'(count);
    @(posedge clk_i);
    cfg_idx_i <= CFG_IMAGE_X; cfg_data_i <= ox;
    @(posedge clk_i);
    cfg_idx_i <= CFG_IMAGE_Y; cfg_data_i <= oy;
    @(posedge clk_i);
    cfg_idx_i <= CFG_IMAGE_Z; cfg_data_i <= oz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Positions mostly near a cluster center so that terms are large
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return cluster + 32'($signed($urandom_range(1 << 21)) - (1 << 20));
  endfunction

  function automatic logic [63:0] rand_prior();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(1 << 16));
      2: return 64'h8000_0000_0000_0000 + 64'($urandom_range(1 << 16));
      default: return 64'($signed($urandom));
    endcase
  endfunction

  function automatic logic [31:0] rand_offset(input int kind);
    case (kind)
      0: return '0;
      1: return $urandom;
      2: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  initial begin
    logic [8:0] cnt;
    int okind;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; cmd_i = CMD_STORE; slot_i = '0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0; charge_i = '0;
    prior_potential_i = '0; prior_force_x_i = '0; prior_force_y_i = '0; prior_force_z_i = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b0;
    cluster = 32'h0100_0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of positions and charges in slots 0..7
    store_source(8'd0, 32'h0100_0000, 32'h0, 32'h0, 32'h0100_0000);
    store_source(8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    store_source(8'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    store_source(8'd3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0);
    store_source(8'd4, 32'h0, 32'h0100_0000, 32'h0, 32'hFF00_0000);
    store_source(8'd5, 32'h0, 32'h0, 32'h0000_0010, 32'h0000_0001);
    store_source(8'd6, 32'hFF00_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    store_source(8'd7, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    // No sources: prior passes through
    evaluate(32'h0, 32'h0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
             64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_config(9'd8, 32'h0, 32'h0, 32'h0);
    // Coincident with slot 7, then opposite corners, then saturation of the sums
    evaluate(32'h0, 32'h0, 32'h0, 64'h0, 64'h0, 64'h0, 64'h0);
    evaluate(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 64'h1, 64'h2, 64'h3, 64'h4);
    evaluate(32'h0000_0001, 32'h0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF,
             64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    evaluate(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    // Image offsets at both extremes; a target at source 0 plus the offset is coincident
    write_config(9'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    evaluate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h0, 64'h0, 64'h0, 64'h0);
    evaluate(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 64'h0, 64'h0, 64'h0, 64'h0);
    write_config(9'd1, 32'h0100_0000, 32'h0, 32'h0);
    evaluate(32'h0200_0000, 32'h0, 32'h0, 64'h0, 64'h0, 64'h0, 64'h0);

    // Fill every slot and walk them all with a count above the memory size
    for (int i = 0; i < NSRC; i++)
      store_source(8'(i), rand_coord(), rand_coord(), rand_coord(), $urandom);
    write_config(9'h1FF, 32'h0, 32'h0, 32'h0);
    evaluate(rand_coord(), rand_coord(), rand_coord(), rand_prior(), rand_prior(),
             rand_prior(), rand_prior());
    write_config(9'd256, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    evaluate($urandom, $urandom, $urandom, 64'h0, 64'h0, 64'h0, 64'h0);

    // Random phases, each with its own registers and idle pattern
    for (int ph = 0; ph < 8; ph++) begin
      okind = $urandom_range(3);
      cnt = ($urandom_range(4) == 0) ? 9'($urandom_range(12)) : 9'($urandom_range(2));
      write_config(cnt, rand_offset(okind), rand_offset(okind), rand_offset(okind));
      cluster = $urandom;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // hold the receiver off long enough for evaluations to back up
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(3) != 0)
          store_source(8'($urandom_range(cnt > 0 ? 2 * cnt : 7)), rand_coord(),
                       rand_coord(), rand_coord(), $urandom);
        else if ($urandom_range(9) == 0)
          store_source(8'($urandom), $urandom, $urandom, $urandom, $urandom);
        else
          evaluate(rand_coord(), rand_coord(), rand_coord(), rand_prior(), rand_prior(),
                   rand_prior(), rand_prior());
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
